[rtl/vswc_pkg.sv]
// Shared types, constants and codes for the voxel shape write counter.
package vswc_pkg;

  // Scan and write limits
  localparam int unsigned SCAN_LIMIT = 262144;
  localparam int unsigned WRITE_CAP  = 65536;

  // Field widths
  localparam int unsigned COUNT_W = 19;   // holds SCAN_LIMIT
  localparam int unsigned WLIM_W  = 17;   // holds WRITE_CAP
  localparam int unsigned COORD_W = 32;
  localparam int unsigned WIDE_W  = 34;   // coordinate arithmetic without overflow

  // Sphere offsets: a passing sphere is at most 63 voxels wide, so |d| <= 31
  localparam int unsigned DELTA_W = 7;
  localparam int unsigned SQ_W    = 2 * DELTA_W;
  localparam int unsigned DIST_W  = SQ_W + 2;

  localparam logic [WLIM_W-1:0] WRITE_LIMIT_RESET = WLIM_W'(WRITE_CAP);

  // Edit kinds and shapes
  localparam logic [1:0] KIND_REMOVE  = 2'd0;
  localparam logic [1:0] KIND_ADD     = 2'd1;
  localparam logic [1:0] KIND_PAINT   = 2'd2;
  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0]                op_kind;
    logic [1:0]                op_shape;
    logic signed [COORD_W-1:0] radius_q16;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic signed [COORD_W-1:0] extent_x;
    logic signed [COORD_W-1:0] extent_y;
    logic signed [COORD_W-1:0] extent_z;
  } edit_t;

  typedef struct packed {
    logic               ok;
    logic [WLIM_W-1:0]  writes;
    logic [COUNT_W-1:0] scans;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AXIS,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;       // capture the edit word
    logic       check;      // validate, square the radius, seed the volume
    logic       axis_en;    // bound and volume step on one axis
    logic [1:0] axis;
    logic       scan_init;  // park the scan at the low corner
    logic       scan_en;    // test one voxel
    logic       finish;     // apply the write limit and emit
    logic       abort;      // emit a failed result
  } vswc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic check_fail;
    logic axis_fail;
    logic sphere;
    logic scan_last;
  } vswc_stat_t;

endpackage

[rtl/voxel_shape_write_counter.sv]
// Top level of the voxel shape write counter: controller plus datapath.
//
//   channel   | handshake              | word
//   ----------+------------------------+-----------------------------------
//   edit      | start, busy            | edit_t: kind, shape, radius, centre, extents
//   result    | result_valid (strobe)  | result_t: ok, writes, scans
//   config    | cfg_valid, cfg_ready   | cfg_data: write limit, 17 bits
//
// An edit word is taken when start is high and busy is low. A box, or any
// edit that fails a check, goes to its strobe without a scan; a sphere also
// scans every voxel of its bounding cube, (2r+1)^3 with r the integer radius,
// with a single-voxel distance test per step of the scan loop
// (at most 63^3 = 250047 voxels pass the scan limit).
// Reset is synchronous: the sequencer returns to idle, the write limit goes to
// 65536. Each result shows for one cycle only; the receiver cannot stall it. The
// config channel is always ready; write it only while busy is low (unchecked).
module voxel_shape_write_counter
  import vswc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  edit_t             edit,
  output logic              result_valid,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WLIM_W-1:0] cfg_data
);

  vswc_cmd_t  cmd;
  vswc_stat_t stat;

  // Config register takes a word every cycle
  assign cfg_ready = 1'b1;

  // Sequencer: check, three axis steps, then scan for spheres
  vswc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Arithmetic, scan counters and result register
  vswc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .edit         (edit),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[rtl/vswc_ctrl.sv]
// Sequencer for the voxel shape write counter.
module vswc_ctrl
  import vswc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  vswc_stat_t stat,
  output vswc_cmd_t  cmd,
  output logic       busy
);

  state_t     state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        axis_next = AXIS_X;
        if (stat.check_fail) begin
          cmd.abort  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_AXIS;
        end
      end
      ST_AXIS: begin
        cmd.axis_en = 1'b1;
        if (stat.axis_fail) begin
          cmd.abort  = 1'b1;
          state_next = ST_IDLE;
        end else if (axis == AXIS_Z) begin
          if (stat.sphere) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/vswc_datapath.sv]
// Datapath: edit capture, bounds, volume, sphere scan, write limit and result.
module vswc_datapath
  import vswc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [WLIM_W-1:0] cfg_data,
  input  edit_t       edit,
  input  vswc_cmd_t   cmd,
  output vswc_stat_t  stat,
  output logic        result_valid,
  output result_t     result
);

  edit_t               edit_q;
  logic [WLIM_W-1:0]   write_limit;
  logic [COORD_W-1:0]  lim;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  written;
  logic signed [DELTA_W-1:0] dx, dy, dz;

  logic sphere;
  assign sphere = (edit_q.op_shape == SHAPE_SPHERE);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      write_limit <= WRITE_LIMIT_RESET;
    end else if (cfg_we) begin
      write_limit <= cfg_data;
    end
  end

  // Validation
  logic [2*COORD_W-1:0] r2;
  logic                 check_fail;
  assign r2 = $unsigned(edit_q.radius_q16) * $unsigned(edit_q.radius_q16);
  assign check_fail = (write_limit == '0) || (write_limit > WLIM_W'(WRITE_CAP)) ||
                      (edit_q.op_kind != KIND_REMOVE && edit_q.op_kind != KIND_ADD &&
                       edit_q.op_kind != KIND_PAINT) ||
                      (edit_q.op_shape != SHAPE_SPHERE && edit_q.op_shape != SHAPE_BOX) ||
                      (sphere && (edit_q.radius_q16[COORD_W-1] || edit_q.radius_q16 == '0));

  // Per-axis bounds and volume
  logic signed [COORD_W-1:0] c_sel, e_sel;
  logic signed [WIDE_W-1:0]  c_wide, ext_wide, lo_wide, hi_wide;
  logic [WIDE_W-1:0]         w_wide;
  logic [2*COUNT_W-1:0]      prod;
  logic                      bound_fail, e_fail, wide_fail, prod_fail;

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin c_sel = edit_q.centre_x; e_sel = edit_q.extent_x; end
      AXIS_Y:  begin c_sel = edit_q.centre_y; e_sel = edit_q.extent_y; end
      default: begin c_sel = edit_q.centre_z; e_sel = edit_q.extent_z; end
    endcase
  end

  assign c_wide   = $signed({{(WIDE_W-COORD_W){c_sel[COORD_W-1]}}, c_sel});
  assign ext_wide = sphere ? $signed({(WIDE_W-15)'(0), edit_q.radius_q16[30:16]})
                           : $signed({{(WIDE_W-COORD_W){e_sel[COORD_W-1]}}, e_sel});
  assign lo_wide  = c_wide - ext_wide;
  assign hi_wide  = c_wide + ext_wide + $signed({(WIDE_W-1)'(0), sphere});
  // In the 32-bit range when the top three bits agree
  assign bound_fail = !(lo_wide[WIDE_W-1:COORD_W-1] == 3'b000 ||
                        lo_wide[WIDE_W-1:COORD_W-1] == 3'b111) ||
                      !(hi_wide[WIDE_W-1:COORD_W-1] == 3'b000 ||
                        hi_wide[WIDE_W-1:COORD_W-1] == 3'b111);
  assign e_fail    = !sphere && (e_sel[COORD_W-1] || e_sel == '0);
  assign w_wide    = sphere ? {(WIDE_W-16)'(0), edit_q.radius_q16[30:16], 1'b1}
                            : {1'b0, e_sel, 1'b0};
  assign wide_fail = (w_wide > WIDE_W'(SCAN_LIMIT));
  assign prod      = count * w_wide[COUNT_W-1:0];
  assign prod_fail = (prod > (2*COUNT_W)'(SCAN_LIMIT));

  // Sphere scan: offsets from the centre, x fastest
  logic signed [DELTA_W-1:0] ext_d, neg_ext;
  logic [SQ_W-1:0]           sqx, sqy, sqz;
  logic [DIST_W-1:0]         dist_sq;
  logic                      x_end, y_end, z_end, in_shape;

  assign ext_d    = $signed({1'b0, edit_q.radius_q16[16 +: DELTA_W-1]});
  assign neg_ext  = -ext_d;
  assign x_end    = (dx == ext_d);
  assign y_end    = (dy == ext_d);
  assign z_end    = (dz == ext_d);
  assign sqx      = dx * dx;
  assign sqy      = dy * dy;
  assign sqz      = dz * dz;
  assign dist_sq  = DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
  assign in_shape = (COORD_W'(dist_sq) <= lim);

  always_ff @(posedge clk) begin
    if (cmd.load) edit_q <= edit;
    if (cmd.check) begin
      lim   <= r2[2*COORD_W-1:COORD_W];
      count <= COUNT_W'(1);
    end
    if (cmd.axis_en) count <= prod[COUNT_W-1:0];
    if (cmd.scan_init) begin
      dx      <= neg_ext;
      dy      <= neg_ext;
      dz      <= neg_ext;
      written <= '0;
    end else if (cmd.scan_en) begin
      if (in_shape) written <= written + COUNT_W'(1);
      if (x_end) begin
        dx <= neg_ext;
        if (y_end) begin
          dy <= neg_ext;
          dz <= dz + DELTA_W'(1);
        end else begin
          dy <= dy + DELTA_W'(1);
        end
      end else begin
        dx <= dx + DELTA_W'(1);
      end
    end
  end

  // Write limit and result
  logic [COUNT_W-1:0] wr;
  logic               over;
  assign wr   = sphere ? written : count;
  assign over = (wr > COUNT_W'(write_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish || cmd.abort;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.abort || (cmd.finish && over)) begin
      result <= '0;
    end else if (cmd.finish) begin
      result.ok     <= 1'b1;
      result.writes <= wr[WLIM_W-1:0];
      result.scans  <= count;
    end
  end

  assign stat.check_fail = check_fail;
  assign stat.axis_fail  = bound_fail || e_fail || wide_fail || prod_fail;
  assign stat.sphere     = sphere;
  assign stat.scan_last  = x_end && y_end && z_end;

endmodule

[tb/sv/voxel_shape_write_counter_test.sv]
// Self-checking testbench for the voxel shape write counter: directed and random edits.
`timescale 1ns / 1ps

module voxel_shape_write_counter_test
  import vswc_pkg::*;
();

  // Signed 32-bit coordinate range, widened for bound arithmetic
  localparam longint COORD_MIN = -64'sh8000_0000;
  localparam longint COORD_MAX = 64'sh7FFF_FFFF;
  localparam longint SCAN_MAX  = 64'sd262144;

  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;

  // Codes the package leaves unnamed: the invalid kind and shapes
  localparam logic [1:0] KIND_BAD     = 2'd3;
  localparam logic [1:0] SHAPE_BAD    = 2'd2;
  localparam logic [1:0] SHAPE_BAD_HI = 2'd3;

  // Limit values beyond the legal range of the write limit register
  localparam logic [WLIM_W-1:0] LIMIT_OFF  = '0;
  localparam logic [WLIM_W-1:0] LIMIT_OVER = '1;

  // A large sphere holds the block busy through its scan of up to 250047 voxels
  // with no handshake; allow three such scans back to back before calling it a hang.
  localparam int unsigned STALL_LIMIT = 800000;

  // Expected-count store and voxel count predictor
  class voxel_count_scoreboard;
    logic [WLIM_W-1:0]  write_limit;
    longint             box_low[3];
    longint             box_high[3];
    longint             scan_pos[3];
    logic [WLIM_W-1:0]  inside_count;
    logic [COUNT_W-1:0] volume_count;
    result_t            expected_counts[$];
    int unsigned        mismatches;

    function new();
      int a;
      write_limit = WRITE_LIMIT_RESET;
      for (a = 0; a < 3; a++) begin
        box_low[a]  = 0;
        box_high[a] = 0;
        scan_pos[a] = 0;
      end
      inside_count = '0;
      volume_count = '0;
      mismatches   = 0;
    endfunction

    function void flag_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endfunction

    // Failed edit: zero counts, and zero the box when validation failed
    function result_t reject(bit clear_box);
      int a;
      if (clear_box) begin
        for (a = 0; a < 3; a++) begin
          box_low[a]  = 0;
          box_high[a] = 0;
        end
      end
      inside_count = '0;
      volume_count = '0;
      return '0;
    endfunction

    function result_t count_voxel_writes(edit_t e);
      longint  ctr[3], half[3], lo[3], hi[3];
      longint  radius, reach, span, volume, hits, r2_floor, dsq;
      longint  dx, dy, dz;
      bit      sphere;
      int      a;
      result_t res;
      res       = '0;
      radius    = longint'($signed(e.radius_q16));
      ctr[0]    = longint'($signed(e.centre_x));
      ctr[1]    = longint'($signed(e.centre_y));
      ctr[2]    = longint'($signed(e.centre_z));
      half[0]   = longint'($signed(e.extent_x));
      half[1]   = longint'($signed(e.extent_y));
      half[2]   = longint'($signed(e.extent_z));
      sphere    = (e.op_shape == SHAPE_SPHERE);

      if (write_limit == 0 || write_limit > WRITE_CAP) return reject(1'b1);
      if (e.op_kind > KIND_PAINT || e.op_shape > SHAPE_BOX || (sphere && radius <= 0))
        return reject(1'b1);

      // Bounds: a box spans [c-e, c+e), a sphere [c-r, c+r] with r the integer radius
      for (a = 0; a < 3; a++) begin
        reach = sphere ? (radius >>> 16) : half[a];
        if (!sphere && reach <= 0) return reject(1'b1);
        lo[a] = ctr[a] - reach;
        hi[a] = ctr[a] + reach + longint'(sphere);
        if (lo[a] < COORD_MIN || hi[a] > COORD_MAX || hi[a] <= lo[a]) return reject(1'b1);
      end
      for (a = 0; a < 3; a++) begin
        box_low[a]  = lo[a];
        box_high[a] = hi[a];
      end

      volume = 1;
      for (a = 0; a < 3; a++) begin
        span = hi[a] - lo[a];
        if (span > SCAN_MAX || volume > SCAN_MAX / span) return reject(1'b0);
        volume = volume * span;
      end

      if (sphere) begin
        // Exact test: d^2 * 2^32 <= radius^2, i.e. d^2 <= floor(radius^2 / 2^32)
        reach    = radius >>> 16;
        r2_floor = (radius * radius) >>> 32;
        hits     = 0;
        for (dz = -reach; dz <= reach; dz++)
          for (dy = -reach; dy <= reach; dy++)
            for (dx = -reach; dx <= reach; dx++) begin
              dsq = dx * dx + dy * dy + dz * dz;
              if (dsq <= r2_floor) hits++;
            end
        for (a = 0; a < 3; a++) scan_pos[a] = hi[a] - 1;
      end else begin
        hits = volume;
      end

      if (hits > longint'(write_limit)) return reject(1'b0);
      inside_count = hits[WLIM_W-1:0];
      volume_count = volume[COUNT_W-1:0];
      res.ok       = 1'b1;
      res.writes   = inside_count;
      res.scans    = volume_count;
      return res;
    endfunction

    function void note_edit(edit_t e);
      expected_counts.push_back(count_voxel_writes(e));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_counts.size() == 0) begin
        flag_mismatch($sformatf("result ok=%0d writes=%0d scans=%0d with no edit pending",
                                got.ok, got.writes, got.scans));
        return;
      end
      want = expected_counts.pop_front();
      if (got.ok !== want.ok)
        flag_mismatch($sformatf("ok %0d, expected %0d", got.ok, want.ok));
      if (got.writes !== want.writes)
        flag_mismatch($sformatf("writes %0d, expected %0d", got.writes, want.writes));
      if (got.scans !== want.scans)
        flag_mismatch($sformatf("scans %0d, expected %0d", got.scans, want.scans));
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  edit_t             edit;
  logic              result_valid;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WLIM_W-1:0] cfg_data;

  voxel_count_scoreboard sb;
  int unsigned           stall_cycles;

  voxel_shape_write_counter u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .edit         (edit),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every strobed result word against the oldest expectation.
  // Outputs are read at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Watchdog: count cycles with no edit taken and no result strobed
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("voxel_shape_write_counter regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic edit_t make_edit(input logic [1:0] kind, input logic [1:0] shape,
                                      input logic [31:0] radius,
                                      input logic [31:0] cx, cy, cz,
                                      input logic [31:0] ex, ey, ez);
    edit_t e;
    e.op_kind    = kind;
    e.op_shape   = shape;
    e.radius_q16 = radius;
    e.centre_x   = cx;
    e.centre_y   = cy;
    e.centre_z   = cz;
    e.extent_x   = ex;
    e.extent_y   = ey;
    e.extent_z   = ez;
    return e;
  endfunction

  // Mostly anywhere, sometimes hugging either end of the coordinate range
  function automatic logic [31:0] pick_centre();
    int unsigned u;
    u = $urandom_range(99);
    if (u < 8) return C_MAX - $urandom_range(40);
    if (u < 16) return C_MIN + $urandom_range(40);
    return $urandom;
  endfunction

  // Well-formed edits with random content, plus broken edits and raw noise
  function automatic edit_t random_edit();
    edit_t       e;
    int unsigned pick;
    logic [15:0] whole;
    pick       = $urandom_range(99);
    e.op_kind  = 2'($urandom_range(KIND_PAINT, KIND_REMOVE));
    e.op_shape = 2'($urandom_range(SHAPE_BOX, SHAPE_SPHERE));
    e.centre_x = pick_centre();
    e.centre_y = pick_centre();
    e.centre_z = pick_centre();
    if (e.op_shape == SHAPE_SPHERE) begin
      // Keep most spheres small: the scan visits every voxel of the cube
      whole        = ($urandom_range(99) < 85) ? 16'($urandom_range(4)) :
                                                 16'($urandom_range(10, 5));
      e.radius_q16 = {whole, 16'($urandom)};
      e.extent_x   = $urandom;
      e.extent_y   = $urandom;
      e.extent_z   = $urandom;
    end else begin
      e.radius_q16 = $urandom;
      e.extent_x   = ($urandom_range(99) < 10) ? $urandom_range(70, 25) : $urandom_range(24, 1);
      e.extent_y   = $urandom_range(24, 1);
      e.extent_z   = $urandom_range(24, 1);
    end

    if (pick < 15) begin
      // Raw noise: every bit of every field free
      e = make_edit(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
    end else if (pick < 27) begin
      // Break one thing in an otherwise good edit
      case ($urandom_range(4))
        0: begin
          e.op_kind = KIND_BAD;
        end
        1: begin
          e.op_shape = ($urandom_range(1)) ? SHAPE_BAD : SHAPE_BAD_HI;
        end
        2: begin
          e.op_shape   = SHAPE_SPHERE;
          e.radius_q16 = -$signed($urandom_range(70000));
        end
        3: begin
          e.op_shape = SHAPE_BOX;
          e.extent_y = -$signed($urandom_range(5));
        end
        default: begin
          e.op_shape = SHAPE_BOX;
          e.extent_z = $urandom;
        end
      endcase
    end
    return e;
  endfunction

  // Hold the word and start until the block takes it
  task automatic send_edit(input edit_t e);
    edit  <= e;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_edit(e);
  endtask

  // Drain all results, let the block settle, then write the limit register
  task automatic set_write_limit(input logic [WLIM_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy !== 1'b0);
    repeat (6) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.write_limit = value;
  endtask

  // Edge cases run against the reset value of the write limit
  task automatic directed_edits();
    // small boxes and tiny spheres across all kinds, sphere radii fractional and whole
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, 0, 0, 1, 1, 1));
    send_edit(make_edit(KIND_REMOVE, SHAPE_BOX, 32'hFFFF_FFFF, -5, 7, 100, 3, 2, 1));
    send_edit(make_edit(KIND_PAINT, SHAPE_SPHERE, 1, 0, 0, 0, 0, 0, 0));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'h0001_0000, 10, -10, 3, -1, -1, -1));
    send_edit(make_edit(KIND_PAINT, SHAPE_SPHERE, 32'h0001_8000, 0, 0, 0, 0, 0, 0));
    // invalid kind and shapes
    send_edit(make_edit(KIND_BAD, SHAPE_BOX, 0, 0, 0, 0, 2, 2, 2));
    send_edit(make_edit(KIND_ADD, SHAPE_BAD, 32'h0001_0000, 0, 0, 0, 2, 2, 2));
    send_edit(make_edit(KIND_ADD, SHAPE_BAD_HI, 32'h0001_0000, 0, 0, 0, 2, 2, 2));
    // non-positive radius and extents
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 0, 0, 0, 0, 1, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, C_MIN, 0, 0, 0, 1, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, 0, 0, 0, 1, 1));
    send_edit(make_edit(KIND_REMOVE, SHAPE_BOX, 0, 0, 0, 0, 1, 1, C_MIN));
    // bounds at and past the coordinate range
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, C_MAX, 0, 0, 1, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, C_MIN, 0, 1, 1, 1));
    send_edit(make_edit(KIND_PAINT, SHAPE_BOX, 0, C_MAX - 1, C_MIN + 1, 0, 1, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'h0001_0000, 0, 0, C_MAX - 2, 0, 0, 0));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'h0001_0000, 0, 0, C_MAX - 1, 0, 0, 0));
    // volume: one huge axis, exactly the scan limit, writes at the cap, one past
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, 0, 0, C_MAX, 1, 1));
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, 0, 0, 32, 32, 32));
    send_edit(make_edit(KIND_REMOVE, SHAPE_BOX, 0, 0, 0, 0, 32, 32, 8));
    send_edit(make_edit(KIND_ADD, SHAPE_BOX, 0, 0, 0, 0, 33, 32, 32));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'h0020_0000, 0, 0, 0, 0, 0, 0));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, C_MAX, 0, 0, 0, 0, 0, 0));
    // a large sphere that passes, then the widest cube the scan limit allows
    send_edit(make_edit(KIND_PAINT, SHAPE_SPHERE, 32'h0014_0000, 100, -100, 7, 0, 0, 0));
    send_edit(make_edit(KIND_ADD, SHAPE_SPHERE, 32'h001F_FFFF, -3, 3, 0, 0, 0, 0));
  endtask

  // Random edits; idle_pct sets how often the sender drops start between words
  task automatic random_edits(input int unsigned count, input int unsigned idle_pct);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) begin
        // hold off until every expected result is back
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
      end
      send_edit(random_edit());
    end
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    start     = 1'b0;
    edit      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_edits();

    // Each phase rewrites the limit while idle, then streams edits
    set_write_limit(WRITE_LIMIT_RESET);
    random_edits(18, 0);
    set_write_limit(LIMIT_OFF);
    random_edits(5, 60);
    set_write_limit(LIMIT_OVER);
    random_edits(5, 6);
    set_write_limit(WLIM_W'(1));
    random_edits(8, 0);
    set_write_limit(WLIM_W'($urandom_range(400, 8)));
    random_edits(18, 60);
    set_write_limit(WLIM_W'($urandom_range(WRITE_CAP, 1)));
    random_edits(20, 6);

    // Drain, then watch a little longer for stray strobes
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (16) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("voxel_shape_write_counter regression: pass");
    end else begin
      $display("voxel_shape_write_counter regression: fail");
    end
    $finish;
  end

endmodule
